FILE: design/double_ended_queue_top_macros.svh
// shared assertion macros for the deque checker
`ifndef DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH

// same-cycle implication, sampled on the rising clock outside reset
`define DQ_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("deque check failed");

// next-cycle implication, sampled on the rising clock outside reset
`define DQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("deque check failed");

`endif

FILE: design/dq_pkg.sv
`timescale 1ns / 1ps

package dq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int REQ_W      = 3;

    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd4;
    localparam logic [REQ_W-1:0] REQ_QUERY      = 3'd5;

    typedef logic [DATA_WIDTH-1:0] t_word;
    typedef logic [CNT_W-1:0]      t_count;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        t_word            data_word;
    } t_req;

    typedef struct packed {
        t_word  front_word;
        t_word  back_word;
        t_word  popped_word;
        t_count element_count;
        logic   is_empty;
        logic   op_error;
    } t_rsp;

    // one-hot shift/write controls broadcast to every cell
    typedef struct packed {
        logic clear;
        logic add_back;
        logic add_front;
        logic take_back;
        logic take_front;
    } t_cell_ctrl;

endpackage

FILE: design/dq_if.sv
`timescale 1ns / 1ps

interface dq_req_if;
    logic        valid;
    logic        ready;
    dq_pkg::t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface dq_rsp_if;
    logic        valid;
    logic        ready;
    dq_pkg::t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: design/dq_cell.sv
`timescale 1ns / 1ps

module dq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dq_pkg::t_cell_ctrl i_ctrl,
    input  dq_pkg::t_word      i_word,
    input  dq_pkg::t_word      i_left_data,
    input  logic               i_left_valid,
    input  dq_pkg::t_word      i_right_data,
    input  logic               i_right_valid,
    output dq_pkg::t_word      o_data,
    output logic               o_valid,
    output dq_pkg::t_word      o_next_data,
    output logic               o_next_valid
);

    dq_pkg::t_word r_data;
    dq_pkg::t_word n_data;
    logic          r_valid;
    logic          n_valid;

    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        if (i_ctrl.clear) begin
            n_valid = 1'b0;
        end else if (i_ctrl.add_front) begin
            n_data  = i_left_data;
            n_valid = i_left_valid;
        end else if (i_ctrl.add_back) begin
            // first empty cell takes the word
            if (!r_valid && i_left_valid) begin
                n_data  = i_word;
                n_valid = 1'b1;
            end
        end else if (i_ctrl.take_front) begin
            n_data  = i_right_data;
            n_valid = i_right_valid;
        end else if (i_ctrl.take_back) begin
            // tail cell drops out
            n_valid = r_valid & i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data       = r_data;
    assign o_valid      = r_valid;
    assign o_next_data  = n_data;
    assign o_next_valid = n_valid;

endmodule

FILE: design/double_ended_queue_top.sv
`timescale 1ns / 1ps
// a request's result is registered and shows in the cycle after acceptance
// throughput: one request per cycle; the whole cell row shifts or writes in one step
// a stalled result holds off the next request until the output register is taken
// reset (synchronous, active low) clears every cell valid bit and the count
// there is no clearing pass; cell data is never reset

module double_ended_queue_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dq_req_if.sink          i_req,
    dq_rsp_if.source        o_rsp
);

    localparam int DEPTH = dq_pkg::DEPTH;

    dq_pkg::t_word      w_data      [DEPTH];
    logic               w_valid     [DEPTH];
    dq_pkg::t_word      w_next_data [DEPTH];
    logic               w_next_valid[DEPTH];
    dq_pkg::t_cell_ctrl w_ctrl;

    dq_pkg::t_rsp   r_rsp;
    dq_pkg::t_rsp   n_rsp;
    logic           r_out_valid;
    dq_pkg::t_count r_count;
    dq_pkg::t_count n_count;

    logic          w_fire;
    logic          w_full;
    logic          w_empty;
    logic          w_err;
    dq_pkg::t_word w_back_now;
    dq_pkg::t_word w_back_next;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_fire      = i_req.valid && i_req.ready;
    assign w_full      = w_valid[DEPTH-1];
    assign w_empty     = !w_valid[0];

    always_comb begin
        w_ctrl = '0;
        w_err  = 1'b0;
        case (i_req.payload.req_type)
            dq_pkg::REQ_PUSH_BACK: begin
                w_err           = w_full;
                w_ctrl.add_back = w_fire && !w_full;
            end
            dq_pkg::REQ_PUSH_FRONT: begin
                w_err            = w_full;
                w_ctrl.add_front = w_fire && !w_full;
            end
            dq_pkg::REQ_POP_BACK: begin
                w_err            = w_empty;
                w_ctrl.take_back = w_fire && !w_empty;
            end
            dq_pkg::REQ_POP_FRONT: begin
                w_err             = w_empty;
                w_ctrl.take_front = w_fire && !w_empty;
            end
            dq_pkg::REQ_CLEAR: begin
                w_ctrl.clear = w_fire;
            end
            default: begin
                w_err = 1'b0;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            dq_pkg::t_word w_left_data;
            logic          w_left_valid;
            dq_pkg::t_word w_right_data;
            logic          w_right_valid;

            if (gi == 0) begin : g_head
                assign w_left_data  = i_req.payload.data_word;
                assign w_left_valid = 1'b1;
            end else begin : g_mid
                assign w_left_data  = w_data[gi-1];
                assign w_left_valid = w_valid[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_tail
                assign w_right_data  = '0;
                assign w_right_valid = 1'b0;
            end else begin : g_inner
                assign w_right_data  = w_data[gi+1];
                assign w_right_valid = w_valid[gi+1];
            end

            dq_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (w_ctrl),
                .i_word       (i_req.payload.data_word),
                .i_left_data  (w_left_data),
                .i_left_valid (w_left_valid),
                .i_right_data (w_right_data),
                .i_right_valid(w_right_valid),
                .o_data       (w_data[gi]),
                .o_valid      (w_valid[gi]),
                .o_next_data  (w_next_data[gi]),
                .o_next_valid (w_next_valid[gi])
            );
        end
    endgenerate

    // back word: one-hot select of the last occupied cell, now and after the request
    always_comb begin
        w_back_now  = '0;
        w_back_next = '0;
        for (int i = 0; i < DEPTH - 1; i++) begin
            if (w_valid[i] && !w_valid[i+1]) w_back_now = w_back_now | w_data[i];
            if (w_next_valid[i] && !w_next_valid[i+1]) begin
                w_back_next = w_back_next | w_next_data[i];
            end
        end
        if (w_valid[DEPTH-1]) w_back_now = w_back_now | w_data[DEPTH-1];
        if (w_next_valid[DEPTH-1]) w_back_next = w_back_next | w_next_data[DEPTH-1];
    end

    always_comb begin
        n_count = r_count;
        if (w_ctrl.clear) begin
            n_count = '0;
        end else if (w_ctrl.add_back || w_ctrl.add_front) begin
            n_count = r_count + dq_pkg::CNT_W'(1);
        end else if (w_ctrl.take_back || w_ctrl.take_front) begin
            n_count = r_count - dq_pkg::CNT_W'(1);
        end
    end

    always_comb begin
        n_rsp               = '0;
        n_rsp.front_word    = w_next_valid[0] ? w_next_data[0] : '0;
        n_rsp.back_word     = w_back_next;
        n_rsp.element_count = n_count;
        n_rsp.is_empty      = !w_next_valid[0];
        n_rsp.op_error      = w_err;
        if (w_ctrl.take_back) begin
            n_rsp.popped_word = w_back_now;
        end else if (w_ctrl.take_front) begin
            n_rsp.popped_word = w_data[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_count <= n_count;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_rsp;

endmodule

FILE: design/dq_chk.sv
`timescale 1ns / 1ps
`include "double_ended_queue_top_macros.svh"

module dq_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_rsp_valid,
    input logic         i_rsp_ready,
    input dq_pkg::t_rsp i_rsp_payload
);

    logic w_count_zero;
    logic w_ends_zero;
    logic w_no_pop;
    logic w_single;
    logic w_ends_equal;

    assign w_count_zero = (i_rsp_payload.element_count == '0);
    assign w_ends_zero  = (i_rsp_payload.front_word == '0) && (i_rsp_payload.back_word == '0);
    assign w_no_pop     = (i_rsp_payload.popped_word == '0);
    assign w_single     = (i_rsp_payload.element_count == dq_pkg::CNT_W'(1));
    assign w_ends_equal = (i_rsp_payload.front_word == i_rsp_payload.back_word);

    `DQ_ASSERT_SAME(a_empty_matches_count, i_rsp_valid, i_rsp_payload.is_empty == w_count_zero)
    `DQ_ASSERT_SAME(a_empty_ends_zero, i_rsp_valid && i_rsp_payload.is_empty, w_ends_zero)
    `DQ_ASSERT_SAME(a_error_no_pop, i_rsp_valid && i_rsp_payload.op_error, w_no_pop)
    `DQ_ASSERT_SAME(a_single_ends_equal, i_rsp_valid && w_single, w_ends_equal)
    `DQ_ASSERT_NEXT(a_stall_holds, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_payload))

endmodule

bind double_ended_queue_top dq_chk u_dq_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_payload(o_rsp.payload)
);

FILE: test/double_ended_queue_top_test.sv
`timescale 1ns / 1ps

module double_ended_queue_top_test;
    import dq_pkg::*;

    // request codes with no operation of their own, answered as a query
    localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

    localparam int RANDOM_REQS    = 500;
    localparam int CALM_TAIL      = 80;
    localparam int WATCHDOG_LIMIT = 1000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    dq_req_if req_ch ();
    dq_rsp_if rsp_ch ();

    double_ended_queue_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_req  pending_reqs[$];
    t_rsp  rsp_expect[$];
    t_rsp  rsp_want;
    t_word ring_words[DEPTH];
    int    ring_head;
    int    ring_held;
    int    n_fail;
    int    gap_left;
    int    stall_left;
    int    quiet_cycles;
    bit    req_idle_on;
    bit    rsp_idle_on;

    // mirror of the deque: applies one request and gives the result it causes
    function automatic t_rsp deque_apply(t_req r);
        t_rsp res;
        res = '0;
        case (r.req_type)
            REQ_PUSH_BACK: begin
                if (ring_held == DEPTH) begin
                    res.op_error = 1'b1;
                end else begin
                    ring_words[(ring_head + ring_held) % DEPTH] = r.data_word;
                    ring_held++;
                end
            end
            REQ_PUSH_FRONT: begin
                if (ring_held == DEPTH) begin
                    res.op_error = 1'b1;
                end else begin
                    ring_head = (ring_head + DEPTH - 1) % DEPTH;
                    ring_words[ring_head] = r.data_word;
                    ring_held++;
                end
            end
            REQ_POP_BACK: begin
                if (ring_held == 0) begin
                    res.op_error = 1'b1;
                end else begin
                    res.popped_word = ring_words[(ring_head + ring_held - 1) % DEPTH];
                    ring_held--;
                end
            end
            REQ_POP_FRONT: begin
                if (ring_held == 0) begin
                    res.op_error = 1'b1;
                end else begin
                    res.popped_word = ring_words[ring_head];
                    ring_head = (ring_head + 1) % DEPTH;
                    ring_held--;
                end
            end
            REQ_CLEAR: begin
                ring_head = 0;
                ring_held = 0;
            end
            default: ;
        endcase
        if (ring_held != 0) begin
            res.front_word = ring_words[ring_head];
            res.back_word  = ring_words[(ring_head + ring_held - 1) % DEPTH];
        end
        res.element_count = t_count'(ring_held);
        res.is_empty      = (ring_held == 0);
        return res;
    endfunction

    task automatic add_req(input logic [REQ_W-1:0] kind, input t_word w);
        t_req r;
        r.req_type  = kind;
        r.data_word = w;
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    task automatic check_field(input string field, input t_word want_v, input t_word got_v);
        if (got_v !== want_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want_v, got_v);
            n_fail++;
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (req_ch.valid && req_ch.ready)
                rsp_expect.insert(rsp_expect.size(), deque_apply(req_ch.payload));
            if ($urandom_range(0, 49) == 0)
                req_idle_on = !req_idle_on;
            if (!req_ch.valid || req_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    req_ch.valid <= 1'b0;
                end else if (req_idle_on && pending_reqs.size() > CALM_TAIL &&
                             $urandom_range(0, 4) == 0) begin
                    gap_left = $urandom_range(0, 9);
                    req_ch.valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    req_ch.valid   <= 1'b1;
                    req_ch.payload <= pending_reqs[0];
                    pending_reqs.delete(0);
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (rsp_expect.size() == 0) begin
                    $error("result with no request outstanding");
                    n_fail++;
                end else begin
                    rsp_want = rsp_expect[0];
                    rsp_expect.delete(0);
                    check_field("front_word", rsp_want.front_word, rsp_ch.payload.front_word);
                    check_field("back_word", rsp_want.back_word, rsp_ch.payload.back_word);
                    check_field("popped_word", rsp_want.popped_word,
                                rsp_ch.payload.popped_word);
                    check_field("element_count", t_word'(rsp_want.element_count),
                                t_word'(rsp_ch.payload.element_count));
                    check_field("is_empty", t_word'(rsp_want.is_empty),
                                t_word'(rsp_ch.payload.is_empty));
                    check_field("op_error", t_word'(rsp_want.op_error),
                                t_word'(rsp_ch.payload.op_error));
                end
            end
            if ($urandom_range(0, 49) == 0)
                rsp_idle_on = !rsp_idle_on;
            if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else if (rsp_idle_on && pending_reqs.size() > CALM_TAIL &&
                         $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 9);
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("double_ended_queue_top test failed");
                $finish;
            end
        end
    end

    initial begin
        t_word w;
        int    mode;
        int    seg_left;
        int    push_pct;
        int    roll;

        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready   = 1'b0;
        ring_head      = 0;
        ring_held      = 0;
        n_fail         = 0;
        quiet_cycles   = 0;
        req_idle_on    = 1'b1;
        rsp_idle_on    = 1'b1;

        // directed: pops on empty, extreme words at both ends, spare codes, clear
        add_req(REQ_POP_BACK, 32'h1234_5678);
        add_req(REQ_POP_FRONT, '1);
        add_req(REQ_PUSH_BACK, '1);
        add_req(REQ_PUSH_FRONT, '0);
        add_req(REQ_QUERY, 32'hdead_beef);
        add_req(REQ_POP_BACK, '0);
        add_req(REQ_POP_FRONT, '0);
        add_req(REQ_PUSH_BACK, 32'haaaa_aaaa);
        add_req(REQ_PUSH_BACK, 32'h5555_5555);
        add_req(REQ_PUSH_FRONT, 32'h0000_0001);
        add_req(REQ_PUSH_FRONT, 32'h8000_0000);
        add_req(REQ_SPARE_LO, '1);
        add_req(REQ_SPARE_HI, '1);
        add_req(REQ_POP_FRONT, '0);
        add_req(REQ_POP_BACK, '0);
        add_req(REQ_CLEAR, '1);
        add_req(REQ_QUERY, '0);
        add_req(REQ_POP_FRONT, '0);
        add_req(REQ_PUSH_FRONT, 32'h7fff_ffff);
        add_req(REQ_POP_BACK, '0);

        // random: stretches biased to fill, to drain, or balanced
        mode     = 0;
        seg_left = 0;
        for (int k = 0; k < RANDOM_REQS; k++) begin
            if (seg_left == 0) begin
                mode     = $urandom_range(0, 2);
                seg_left = $urandom_range(8, 40);
            end
            seg_left--;
            push_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
            case ($urandom_range(0, 7))
                0:       w = '0;
                1:       w = '1;
                default: w = $urandom;
            endcase
            roll = $urandom_range(0, 99);
            if (roll < 2)
                add_req(REQ_CLEAR, w);
            else if (roll < 5)
                add_req(REQ_QUERY, w);
            else if (roll < 7)
                add_req($urandom_range(0, 1) ? REQ_SPARE_HI : REQ_SPARE_LO, w);
            else if ($urandom_range(0, 99) < push_pct)
                add_req($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK, w);
            else
                add_req($urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK, w);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req_ch.valid || rsp_expect.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (n_fail == 0)
            $display("double_ended_queue_top test passed");
        else
            $display("double_ended_queue_top test failed");
        $finish;
    end

endmodule

FILE: double_ended_queue_top.f
+incdir+design
design/dq_pkg.sv
design/dq_if.sv
design/dq_cell.sv
design/double_ended_queue_top.sv
design/dq_chk.sv
test/double_ended_queue_top_test.sv
